FILE: sv/clle_pkg.sv
// Shared constants, types and controller/datapath interface structs for the
// cursor linked list engine. No dependencies.
package clle_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned PTR_W  = $clog2(DEPTH + 1);
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CMP_W  = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ELEM_W-1:0] elem_t;

  // Null link: one past the last slot
  localparam ptr_t NIL = PTR_W'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 2'd0,
    OP_INSERT     = 2'd1,
    OP_ITER_START = 2'd2,
    OP_ITER_NEXT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    LS_NIL  = 2'd0,
    LS_HEAD = 2'd1,
    LS_LINK = 2'd2
  } link_src_e;

  typedef struct packed {
    logic      cap_in;
    logic      walk_load_head;
    logic      walk_step;
    logic      cnt_load;
    logic      rd_cursor;
    logic      cursor_load_head;
    logic      cursor_step;
    logic      write_slot;
    link_src_e link_src;
    logic      head_to_slot;
    logic      write_join;
    logic      count_inc;
    logic      set_acc;
    logic      load_result;
  } clle_cmd_t;

  typedef struct packed {
    op_e  in_op;
    op_e  op;
    logic full;
    logic head_null;
    logic cursor_null;
    logic link_end;
    logic cnt_zero;
    logic pos_ok;
    logic pos_one;
    logic out_free;
  } clle_sts_t;

endpackage

FILE: sv/clle_ctrl.sv
// Controller state machine of the cursor linked list engine.
// Depends on clle_pkg; drives the datapath through clle_cmd_t only.
module clle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  clle_pkg::clle_sts_t sts_i,
  output clle_pkg::clle_cmd_t cmd_o
);
  import clle_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_WALK      = 7'b0000010,
    S_LINK_HEAD = 7'b0000100,
    S_LINK      = 7'b0001000,
    S_JOIN      = 7'b0010000,
    S_READ      = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   walk_done;

  assign walk_done = (sts_i.op == OP_APPEND) ? sts_i.link_end : sts_i.cnt_zero;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          case (sts_i.in_op)
            OP_APPEND: begin
              if (sts_i.full) begin
                state_d = S_DONE;
              end else if (sts_i.head_null) begin
                state_d = S_LINK_HEAD;
              end else begin
                cmd_o.walk_load_head = 1'b1;
                state_d              = S_WALK;
              end
            end
            OP_INSERT: begin
              if (sts_i.full || !sts_i.pos_ok) begin
                state_d = S_DONE;
              end else if (sts_i.pos_one) begin
                state_d = S_LINK_HEAD;
              end else begin
                cmd_o.walk_load_head = 1'b1;
                cmd_o.cnt_load       = 1'b1;
                state_d              = S_WALK;
              end
            end
            OP_ITER_START: begin
              cmd_o.cursor_load_head = 1'b1;
              state_d                = S_DONE;
            end
            OP_ITER_NEXT: begin
              if (sts_i.cursor_null) begin
                state_d = S_DONE;
              end else begin
                cmd_o.rd_cursor = 1'b1;
                state_d         = S_READ;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_d = S_LINK;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_LINK_HEAD: begin
        cmd_o.write_slot   = 1'b1;
        cmd_o.link_src     = (sts_i.op == OP_APPEND) ? LS_NIL : LS_HEAD;
        cmd_o.head_to_slot = 1'b1;
        cmd_o.count_inc    = 1'b1;
        cmd_o.set_acc      = 1'b1;
        state_d            = S_DONE;
      end
      S_LINK: begin
        cmd_o.write_slot = 1'b1;
        cmd_o.link_src   = (sts_i.op == OP_APPEND) ? LS_NIL : LS_LINK;
        cmd_o.count_inc  = 1'b1;
        cmd_o.set_acc    = 1'b1;
        state_d          = S_JOIN;
      end
      S_JOIN: begin
        cmd_o.write_join = 1'b1;
        state_d          = S_DONE;
      end
      S_READ: begin
        cmd_o.cursor_step = 1'b1;
        cmd_o.set_acc     = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/clle_dp.sv
// Datapath of the cursor linked list engine: link and element memories,
// list pointers, walk counter and the result register.
// Depends on clle_pkg; controlled through clle_cmd_t, reports clle_sts_t.
module clle_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [clle_pkg::OP_W-1:0]   operation_i,
  input  logic [clle_pkg::ELEM_W-1:0] element_i,
  input  logic [clle_pkg::POS_W-1:0]  position_i,
  input  clle_pkg::clle_cmd_t         cmd_i,
  output clle_pkg::clle_sts_t         sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic [clle_pkg::ELEM_W-1:0] read_element_o,
  output logic                        more_ahead_o,
  output logic [clle_pkg::CNT_W-1:0]  entry_count_o,
  output logic                        is_full_o,
  output logic                        is_empty_o
);
  import clle_pkg::*;

  ptr_t  link_mem [DEPTH];
  elem_t elem_mem [DEPTH];

  ptr_t  head_q, cursor_q, count_q, walk_q, cnt_q, link_rd_q;
  idx_t  slot_q;
  elem_t elem_q, elem_rd_q;
  op_e   op_q;
  logic  acc_q;

  logic  link_we, link_re;
  idx_t  link_waddr, link_raddr;
  ptr_t  link_wdata, slot_src;
  logic  full;

  logic  out_valid_q;
  logic  out_acc_q, out_more_q, out_full_q, out_empty_q;
  elem_t out_elem_q;
  ptr_t  out_count_q;

  assign full = (count_q == PTR_W'(DEPTH));

  always_comb begin
    case (cmd_i.link_src)
      LS_HEAD: slot_src = head_q;
      LS_LINK: slot_src = link_rd_q;
      default: slot_src = NIL;
    endcase
  end

  assign link_we    = cmd_i.write_slot | cmd_i.write_join;
  assign link_waddr = cmd_i.write_join ? walk_q[IDX_W-1:0] : slot_q;
  assign link_wdata = cmd_i.write_join ? PTR_W'(slot_q) : slot_src;

  assign link_re    = cmd_i.walk_load_head | cmd_i.walk_step | cmd_i.rd_cursor;
  assign link_raddr = cmd_i.walk_load_head ? head_q[IDX_W-1:0] :
                      cmd_i.walk_step      ? link_rd_q[IDX_W-1:0] :
                                             cursor_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_slot) begin
      elem_mem[slot_q] <= elem_q;
    end
    if (cmd_i.rd_cursor) begin
      elem_rd_q <= elem_mem[cursor_q[IDX_W-1:0]];
    end
  end

  // Working registers of one request
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      op_q   <= op_e'(operation_i);
      elem_q <= element_i;
      slot_q <= count_q[IDX_W-1:0];
      acc_q  <= 1'b0;
    end else if (cmd_i.set_acc) begin
      acc_q <= 1'b1;
    end
    if (cmd_i.walk_load_head) begin
      walk_q <= head_q;
    end else if (cmd_i.walk_step) begin
      walk_q <= link_rd_q;
    end
    if (cmd_i.cnt_load) begin
      cnt_q <= PTR_W'(CMP_W'(position_i) - CMP_W'(2));
    end else if (cmd_i.walk_step) begin
      cnt_q <= cnt_q - PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= NIL;
      cursor_q <= NIL;
      count_q  <= '0;
    end else begin
      if (cmd_i.head_to_slot) begin
        head_q <= PTR_W'(slot_q);
      end
      if (cmd_i.cursor_load_head) begin
        cursor_q <= head_q;
      end else if (cmd_i.cursor_step) begin
        cursor_q <= link_rd_q;
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + PTR_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_acc_q   <= acc_q;
      out_elem_q  <= (op_q == OP_ITER_NEXT && acc_q) ? elem_rd_q : '0;
      out_more_q  <= (cursor_q != NIL);
      out_count_q <= count_q;
      out_full_q  <= full;
      out_empty_q <= (count_q == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign read_element_o = out_elem_q;
  assign more_ahead_o   = out_more_q;
  assign entry_count_o  = CNT_W'(out_count_q);
  assign is_full_o      = out_full_q;
  assign is_empty_o     = out_empty_q;

  always_comb begin
    sts_o.in_op       = op_e'(operation_i);
    sts_o.op          = op_q;
    sts_o.full        = full;
    sts_o.head_null   = (head_q == NIL);
    sts_o.cursor_null = (cursor_q == NIL);
    sts_o.link_end    = (link_rd_q == NIL);
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.pos_ok      = (position_i != '0) &&
                        (CMP_W'(position_i) <= CMP_W'(count_q) + CMP_W'(1));
    sts_o.pos_one     = (position_i == POS_W'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

FILE: sv/cursor_linked_list_engine.sv
// Top level of the cursor linked list engine: controller and datapath.
// Depends on clle_pkg, clle_ctrl and clle_dp.
//
// A singly linked list of up to 1024 32-bit words held in a link memory and
// an element memory, one item at a time. Append walks from the head to the
// tail, one link read per cycle; insert at position p walks to the node
// before p, and inserting at the head or appending to an empty list needs
// no walk. Iterator start loads the cursor from the head; iterator next
// reads the element at the cursor and steps the cursor along its link.
// Slots are never freed, so the free list is always the run of slots above
// the element count: the count doubles as the free-list head, and no
// clearing pass follows reset. A new item is taken whenever the engine is
// idle, even while the previous result still waits in the output register;
// the engine then holds its next result until that one is taken. Every
// result carries the count, full and empty flags as they stand after the
// item.
module cursor_linked_list_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [clle_pkg::OP_W-1:0]   operation_i,
  input  logic [clle_pkg::ELEM_W-1:0] element_i,
  input  logic [clle_pkg::POS_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic [clle_pkg::ELEM_W-1:0] read_element_o,
  output logic                        more_ahead_o,
  output logic [clle_pkg::CNT_W-1:0]  entry_count_o,
  output logic                        is_full_o,
  output logic                        is_empty_o
);
  import clle_pkg::*;

  clle_cmd_t cmd;
  clle_sts_t sts;

  // Sequence each item: decode, walk, link, report
  clle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the memories, list pointers and result register
  clle_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .element_i      (element_i),
    .position_i     (position_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .read_element_o (read_element_o),
    .more_ahead_o   (more_ahead_o),
    .entry_count_o  (entry_count_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

  // One item at a time: the engine leaves idle as soon as it takes an item
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("engine took an item while busy");

  // A full list can never be empty
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("result reports full and empty at once");

  // The cursor can only point at a node of a non-empty list
  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(more_ahead_o && is_empty_o))
    else $error("cursor ahead on an empty list");

  // A refused or non-reading item returns a zero element
  a_zero_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (read_element_o == '0))
    else $error("element returned without an accepted read");

endmodule

FILE: test/tb_cursor_linked_list_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for cursor_linked_list_engine: drives list requests
// with random idling on both channels and checks every result against its own
// list model. Depends on clle_pkg and the engine RTL only.
module tb_cursor_linked_list_engine;
  import clle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned RANDOM_ITEMS = 552;
  localparam int unsigned MAX_REPORTS = 10;

  // One result of the engine, in port order
  typedef struct packed {
    logic             accepted;
    elem_t            read_element;
    logic             more_ahead;
    logic [CNT_W-1:0] entry_count;
    logic             is_full;
    logic             is_empty;
  } list_result_t;

  // Keeps a private copy of the list, works out the result of each accepted
  // item and holds it until the engine returns the matching result.
  class list_scoreboard;
    elem_t            word_mem[DEPTH];
    ptr_t             link_mem[DEPTH];
    ptr_t             head;
    ptr_t             free_head;
    ptr_t             cursor;
    logic [CNT_W-1:0] count;
    list_result_t     pending[$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      refusals;
    int unsigned      peak_count;
    int unsigned      op_seen[4];

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        word_mem[i] = '0;
        link_mem[i] = ptr_t'(i + 1);
      end
      head      = NIL;
      free_head = '0;
      cursor    = NIL;
      count     = '0;
    endfunction

    function ptr_t next_of(ptr_t slot);
      if (slot >= DEPTH) return NIL;
      return link_mem[slot];
    endfunction

    // Apply one accepted item to the list copy and queue its result
    function void note_item(op_e op, elem_t elem, logic [POS_W-1:0] pos);
      list_result_t res;
      ptr_t         slot;
      ptr_t         walk;
      logic         full;
      full = (free_head >= DEPTH);
      res  = '0;
      op_seen[op]++;
      case (op)
        OP_APPEND: begin
          if (!full) begin
            slot           = free_head;
            free_head      = next_of(slot);
            word_mem[slot] = elem;
            link_mem[slot] = NIL;
            if (head >= DEPTH) begin
              head = slot;
            end else begin
              walk = head;
              for (int i = 0; i < DEPTH && next_of(walk) != NIL; i++)
                walk = next_of(walk);
              link_mem[walk] = slot;
            end
            count++;
            res.accepted = 1'b1;
          end
        end
        OP_INSERT: begin
          if (!full && pos >= 1 && int'(pos) <= int'(count) + 1) begin
            slot           = free_head;
            free_head      = next_of(slot);
            word_mem[slot] = elem;
            if (pos == 1) begin
              link_mem[slot] = head;
              head           = slot;
            end else begin
              walk = head;
              for (int i = 1; i < int'(pos) - 1 && walk < DEPTH; i++)
                walk = next_of(walk);
              if (walk < DEPTH) begin
                link_mem[slot] = link_mem[walk];
                link_mem[walk] = slot;
              end
            end
            count++;
            res.accepted = 1'b1;
          end
        end
        OP_ITER_START: begin
          cursor = head;
        end
        default: begin
          if (cursor < DEPTH) begin
            res.read_element = word_mem[cursor];
            cursor           = link_mem[cursor];
            res.accepted     = 1'b1;
          end
        end
      endcase
      if (!res.accepted) refusals++;
      if (32'(count) > peak_count) peak_count = 32'(count);
      res.more_ahead  = (cursor < DEPTH);
      res.entry_count = count;
      res.is_full     = (free_head >= DEPTH);
      res.is_empty    = (count == 0);
      pending.push_back(res);
    endfunction

    // Compare one returned result with the oldest expectation
    function void check_result(list_result_t got);
      list_result_t want;
      logic         bad;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: acc=%0b data=%h more=%0b count=%0d full=%0b empty=%0b",
                   got.accepted, got.read_element, got.more_ahead, got.entry_count,
                   got.is_full, got.is_empty);
        return;
      end
      want = pending.pop_front();
      bad  = (got.accepted !== want.accepted)
          || (got.read_element !== want.read_element)
          || (got.more_ahead !== want.more_ahead)
          || (got.entry_count !== want.entry_count)
          || (got.is_full !== want.is_full)
          || (got.is_empty !== want.is_empty);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected acc=%0b data=%h more=%0b count=%0d full=%0b empty=%0b",
                   want.accepted, want.read_element, want.more_ahead, want.entry_count,
                   want.is_full, want.is_empty);
          $display("  actual   acc=%0b data=%h more=%0b count=%0d full=%0b empty=%0b",
                   got.accepted, got.read_element, got.more_ahead, got.entry_count,
                   got.is_full, got.is_empty);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [OP_W-1:0]    operation_i = '0;
  elem_t              element_i = '0;
  logic [POS_W-1:0]   position_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               accepted_o;
  elem_t              read_element_o;
  logic               more_ahead_o;
  logic [CNT_W-1:0]   entry_count_o;
  logic               is_full_o;
  logic               is_empty_o;

  list_scoreboard     sb = new();
  logic               no_idle = 1'b0;
  int unsigned        cycles = 0;

  cursor_linked_list_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .element_i      (element_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .read_element_o (read_element_o),
    .more_ahead_o   (more_ahead_o),
    .entry_count_o  (entry_count_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run; the limit covers thousands of full-length walks
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("cursor_linked_list_engine test failed");
      $finish;
    end
  end

  // Sample results at the edge: values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{accepted_o, read_element_o, more_ahead_o, entry_count_o,
                        is_full_o, is_empty_o});
  end

  // Idle length: mostly none or short, now and then long; none in burst stretches
  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: hold ready high for a while, then drop it for an idle stretch
  initial begin
    int unsigned n;
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      n = idle_cycles();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Present one item after an optional gap and hold it until accepted
  task automatic send_item(op_e op, elem_t elem, logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    element_i   <= elem;
    position_i  <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(op, elem, pos);
    // Flip between idling and burst stretches now and then
    if ($urandom_range(0, 99) < 3) no_idle = ~no_idle;
  endtask

  // Random request: mostly well-formed list traffic, the rest noise
  task automatic send_random();
    int unsigned r;
    int unsigned cnt;
    int unsigned top;
    r   = $urandom_range(0, 99);
    cnt = 32'(sb.count);
    if (r < 30) begin
      // Favour short walks so that the run stays quick
      top = (cnt + 1 < 8) ? cnt + 1 : 8;
      if ($urandom_range(0, 9) < 7)
        send_item(OP_INSERT, $urandom, POS_W'($urandom_range(1, top)));
      else
        send_item(OP_INSERT, $urandom, POS_W'($urandom_range(1, cnt + 1)));
    end else if (r < 48) begin
      send_item(OP_APPEND, $urandom, POS_W'($urandom_range(0, 1024)));
    end else if (r < 57) begin
      send_item(OP_ITER_START, $urandom, POS_W'($urandom_range(0, 1024)));
    end else if (r < 85) begin
      send_item(OP_ITER_NEXT, $urandom, POS_W'($urandom_range(0, 1024)));
    end else if (r < 93) begin
      // Bad position: zero or beyond the end of the list
      if (cnt + 2 <= 1024 && $urandom_range(0, 1))
        send_item(OP_INSERT, $urandom, POS_W'($urandom_range(cnt + 2, 1024)));
      else
        send_item(OP_INSERT, $urandom, '0);
    end else begin
      send_item(op_e'($urandom_range(0, 3)), $urandom, POS_W'($urandom_range(0, 1024)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list corners, refused positions, extremes of the word
    send_item(OP_ITER_NEXT, 32'hFFFF_FFFF, 11'd1024);
    send_item(OP_ITER_START, '0, '0);
    send_item(OP_INSERT, 32'h1234_5678, 11'd0);
    send_item(OP_INSERT, 32'h8765_4321, 11'd2);
    send_item(OP_APPEND, 32'h0000_0000, '0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 11'd1);
    send_item(OP_INSERT, 32'hA5A5_A5A5, 11'd3);
    send_item(OP_INSERT, $urandom, 11'd2);
    send_item(OP_APPEND, $urandom, 11'd1024);
    send_item(OP_INSERT, 32'h5A5A_5A5A, 11'd1024);
    // Walk off the end, then append with the cursor already null
    send_item(OP_ITER_START, '0, '0);
    repeat (6) send_item(OP_ITER_NEXT, '0, '0);
    send_item(OP_APPEND, $urandom, '0);
    send_item(OP_ITER_NEXT, '0, '0);
    // Park the cursor on the tail, append behind it and follow the new link
    send_item(OP_ITER_START, '0, '0);
    repeat (5) send_item(OP_ITER_NEXT, '0, '0);
    send_item(OP_APPEND, $urandom, '0);
    send_item(OP_ITER_NEXT, '0, '0);
    send_item(OP_ITER_NEXT, '0, '0);

    repeat (RANDOM_ITEMS) send_random();

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // Let any stray result surface
    repeat (20) @(posedge clk_i);

    $display("Checked %0d results: %0d appends, %0d inserts, %0d starts, %0d nexts",
             sb.results_seen, sb.op_seen[OP_APPEND], sb.op_seen[OP_INSERT],
             sb.op_seen[OP_ITER_START], sb.op_seen[OP_ITER_NEXT]);
    $display("Refused requests %0d, peak list length %0d, mismatches %0d, left over %0d",
             sb.refusals, sb.peak_count, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("cursor_linked_list_engine test passed");
    end else begin
      $display("cursor_linked_list_engine test failed");
    end
    $finish;
  end

endmodule

FILE: cursor_linked_list_engine.f
sv/clle_pkg.sv
sv/clle_ctrl.sv
sv/clle_dp.sv
sv/cursor_linked_list_engine.sv
test/tb_cursor_linked_list_engine.sv
